>>> sv/servo_angle_to_pwm_duty_assert.svh
// Assertion macros shared by the servo angle to PWM duty RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SERVO_ANGLE_TO_PWM_DUTY_ASSERT_SVH
`define SERVO_ANGLE_TO_PWM_DUTY_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SAPWM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SAPWM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sapwm_pkg.sv
// Shared types and constants for the servo angle to PWM duty block.
// No dependencies; used by sapwm_div and servo_angle_to_pwm_duty.
package sapwm_pkg;

    // Default full-scale duty
    localparam int MAX_DUTY_DEF = 65535;

    // Divider operand widths
    localparam int DIV_DVD_W = 32;
    localparam int DIV_DVS_W = 16;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_SET = 2'd0,
        KIND_ROT = 2'd1,
        KIND_CTR = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [2:0] REG_CYCLE     = 3'd0;
    localparam logic [2:0] REG_FIRST_ANG = 3'd1;
    localparam logic [2:0] REG_FIRST_T   = 3'd2;
    localparam logic [2:0] REG_SECOND_ANG = 3'd3;
    localparam logic [2:0] REG_SECOND_T  = 3'd4;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

>>> sv/servo_angle_to_pwm_duty.sv
// Servo angle to PWM duty: an accepted item goes through these steps to m_tvalid
// (setup, 16x16 multiply, 32-step divide with load and done, add,
// multiply, second divide, load). One item at a time; both divides use the
// shared divider. The next item is taken while a finished
// result waits in the output register; a result still waiting holds that item.
// Reset (aresetn low, synchronous) restores register defaults and angle zero.
// Depends on sapwm_pkg, sapwm_div and servo_angle_to_pwm_duty_assert.svh.
`include "servo_angle_to_pwm_duty_assert.svh"

module servo_angle_to_pwm_duty
    import sapwm_pkg::*;
#(
    parameter int MAX_DUTY = MAX_DUTY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] angle_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] duty, [31:16] current_angle
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [15:0] MaxDuty16 = 16'(MAX_DUTY);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_DIV1 = 7'b0001000,
        S_ADDT = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;

    // configuration
    logic [15:0]        cycle_reg;
    logic signed [15:0] first_ang_reg, second_ang_reg;
    logic [15:0]        first_t_reg, second_t_reg;

    // per-item working registers
    logic signed [15:0] held_reg;
    logic signed [15:0] a_lo_reg, a_hi_reg;
    logic [15:0]        t_lo_reg, t_hi_reg;
    logic [15:0]        d_reg, span_reg, dt_abs_reg;
    logic               dt_neg_reg, eq_reg;
    logic [31:0]        prod_reg;
    logic               start_reg;

    // output register
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    // divider link
    div_ctl_t           div_ctl;
    div_sts_t           div_sts;
    logic [15:0]        div_dvs;
    logic [31:0]        div_q;

    // accept-cycle logic
    logic               swap;
    logic signed [15:0] lo_ang, hi_ang;
    logic [15:0]        lo_t, hi_t;
    logic signed [16:0] tgt, lo17, hi17;
    logic signed [15:0] tgt_clamp;
    logic               in_acc, out_free;

    // prep logic
    logic signed [16:0] d17, span17, dt17;

    // multiplier operands and interpolated pulse time
    logic [15:0]        mul_a, mul_b, t_new;

    // final duty
    logic [15:0]        duty;

    // Interpolated pulse time; stays between the two endpoint times
    function automatic logic [15:0] t_next_val(input logic eq, input logic neg,
                                               input logic [15:0] t_lo,
                                               input logic [15:0] q);
        if (eq)
            return t_lo;
        else if (neg)
            return t_lo - q;
        else
            return t_lo + q;
    endfunction

    assign s_tready  = aresetn && (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = aresetn;

    // Order endpoints, form and clamp the new angle
    always_comb begin
        swap   = (second_ang_reg < first_ang_reg);
        lo_ang = swap ? second_ang_reg : first_ang_reg;
        hi_ang = swap ? first_ang_reg  : second_ang_reg;
        lo_t   = swap ? second_t_reg   : first_t_reg;
        hi_t   = swap ? first_t_reg    : second_t_reg;
        lo17   = {lo_ang[15], lo_ang};
        hi17   = {hi_ang[15], hi_ang};
        case (kind_t'(s_tuser))
            KIND_SET: tgt = {s_tdata[15], s_tdata};
            KIND_ROT: tgt = {held_reg[15], held_reg} + {s_tdata[15], s_tdata};
            KIND_CTR: begin
                if (lo_ang > 16'sd0)
                    tgt = lo17;
                else if (hi_ang < 16'sd0)
                    tgt = hi17;
                else
                    tgt = '0;
            end
            default: tgt = {held_reg[15], held_reg};
        endcase
        if (tgt < lo17)
            tgt_clamp = lo_ang;
        else if (tgt > hi17)
            tgt_clamp = hi_ang;
        else
            tgt_clamp = tgt[15:0];
    end

    // Offsets for the interpolation
    always_comb begin
        d17    = {held_reg[15], held_reg} - {a_lo_reg[15], a_lo_reg};
        span17 = {a_hi_reg[15], a_hi_reg} - {a_lo_reg[15], a_lo_reg};
        dt17   = {1'b0, t_hi_reg} - {1'b0, t_lo_reg};
    end

    // Duty with zero-period and full-scale saturation
    always_comb begin
        if (cycle_reg == 16'd0)
            duty = MaxDuty16;
        else if (div_q > {16'd0, MaxDuty16})
            duty = MaxDuty16;
        else
            duty = div_q[15:0];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc) state_next = S_PREP;
            S_PREP: state_next = S_MUL1;
            S_MUL1: state_next = S_DIV1;
            S_DIV1: if (div_sts.done) state_next = S_ADDT;
            S_ADDT: state_next = S_DIV2;
            S_DIV2: if (div_sts.done) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            start_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            held_reg       <= '0;
            cycle_reg      <= 16'd20000;
            first_ang_reg  <= 16'sd0;
            first_t_reg    <= 16'd500;
            second_ang_reg <= 16'sd180;
            second_t_reg   <= 16'd2500;
        end else begin
            state_reg <= state_next;
            start_reg <= (state_reg == S_MUL1) || (state_reg == S_ADDT);
            if (in_acc)
                held_reg <= tgt_clamp;
            if (state_reg == S_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CYCLE:      cycle_reg      <= cfg_data;
                    REG_FIRST_ANG:  first_ang_reg  <= cfg_data;
                    REG_FIRST_T:    first_t_reg    <= cfg_data;
                    REG_SECOND_ANG: second_ang_reg <= cfg_data;
                    REG_SECOND_T:   second_t_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Shared multiplier operands: |dt| * offset, then MAX_DUTY * t
    assign t_new = t_next_val(eq_reg, dt_neg_reg, t_lo_reg, div_q[15:0]);
    assign mul_a = (state_reg == S_MUL1) ? dt_abs_reg : MaxDuty16;
    assign mul_b = (state_reg == S_MUL1) ? d_reg : t_new;

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            a_lo_reg <= lo_ang;
            a_hi_reg <= hi_ang;
            t_lo_reg <= lo_t;
            t_hi_reg <= hi_t;
        end
        if (state_reg == S_PREP) begin
            d_reg      <= d17[15:0];
            span_reg   <= span17[15:0];
            eq_reg     <= (span17 == 17'sd0);
            dt_neg_reg <= dt17[16];
            dt_abs_reg <= dt17[16] ? 16'(-dt17) : dt17[15:0];
        end
        // shared 16x16 multiplier
        if (state_reg == S_MUL1 || state_reg == S_ADDT)
            prod_reg <= {16'd0, mul_a} * {16'd0, mul_b};
        if (state_reg == S_OUT && out_free)
            m_tdata_reg <= {held_reg, duty};
    end

    assign div_ctl.start = start_reg;
    assign div_dvs       = (state_reg == S_DIV1) ? span_reg : cycle_reg;

    sapwm_div #(
        .DVD_W (DIV_DVD_W),
        .DVS_W (DIV_DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (prod_reg),
        .divisor  (div_dvs),
        .sts      (div_sts),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SAPWM_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, in_acc, !s_tready, "item taken while busy")
    `SAPWM_ASSERT_IMP(a_duty_max, aclk, aresetn, m_tvalid_reg, m_tdata_reg[15:0] <= MaxDuty16, "duty above full scale")
    `SAPWM_ASSERT_IMP(a_done_in_div, aclk, aresetn, div_sts.done, (state_reg == S_DIV1) || (state_reg == S_DIV2), "divider done outside divide step")

endmodule

>>> sv/sapwm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sapwm_pkg and servo_angle_to_pwm_duty_assert.svh.
`include "servo_angle_to_pwm_duty_assert.svh"

module sapwm_div
    import sapwm_pkg::*;
#(
    parameter int DVD_W = DIV_DVD_W,
    parameter int DVS_W = DIV_DVS_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctl_t         ctl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_sts_t         sts,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             q_bit;

    // One trial subtraction per cycle
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        q_bit    = (trial >= {1'b0, dvs_reg});
        rem_next = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    // Control: start loads operands, busy runs DVD_W steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out, quotient bits shift in
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;

    `SAPWM_ASSERT_IMP(a_no_start_busy, aclk, aresetn, ctl.start, !busy_reg, "start while busy")
    `SAPWM_ASSERT_NXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "done longer than one cycle")
    `SAPWM_ASSERT_IMP(a_done_on_finish, aclk, aresetn, $fell(busy_reg), done_reg, "busy fell without done")

endmodule

>>> bench/servo_angle_to_pwm_duty_chk.sv
// Scoreboard for servo_angle_to_pwm_duty: tracks register writes and input items,
// predicts duty and clamped angle for each item, and checks the results in order.
// Depends on sapwm_pkg; instantiated by servo_angle_to_pwm_duty_tb.
module servo_angle_to_pwm_duty_chk
    import sapwm_pkg::*;
#(
    parameter int MAX_DUTY = MAX_DUTY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] angle_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [15:0] duty, [31:16] current_angle
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    // Same layout as m_tdata
    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] duty;
    } servo_result_t;

    // Shadow of the block's registers and held angle
    logic [15:0]        period_us;
    logic signed [15:0] ang_first;
    logic [15:0]        pulse_first;
    logic signed [15:0] ang_second;
    logic [15:0]        pulse_second;
    logic signed [15:0] held_ang;

    servo_result_t expected_results[$];

    task automatic log_mismatch(input string what, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // New held angle and duty for one item
    function automatic servo_result_t predict_servo(input logic [1:0] kind,
                                                    input logic signed [15:0] value);
        longint lo_a, hi_a, lo_t, hi_t, target, t, q;
        servo_result_t res;
        // order the endpoints, pulse times travel with their angle
        if (ang_second < ang_first) begin
            lo_a = ang_second;
            hi_a = ang_first;
            lo_t = pulse_second;
            hi_t = pulse_first;
        end else begin
            lo_a = ang_first;
            hi_a = ang_second;
            lo_t = pulse_first;
            hi_t = pulse_second;
        end
        case (kind)
            KIND_SET: target = value;
            KIND_ROT: target = longint'(held_ang) + longint'(value);
            KIND_CTR: begin
                if (lo_a > 0)
                    target = lo_a;
                else if (hi_a < 0)
                    target = hi_a;
                else
                    target = 0;
            end
            default: target = held_ang;   // unused kind: re-clamp the held angle
        endcase
        if (target < lo_a)
            target = lo_a;
        else if (target > hi_a)
            target = hi_a;
        // signed interpolation, quotient truncated toward zero
        t = lo_t;
        if (hi_a != lo_a)
            t = lo_t + ((hi_t - lo_t) * (target - lo_a)) / (hi_a - lo_a);
        if (t < 0)
            t = 0;
        if (period_us == 16'd0) begin
            q = MAX_DUTY;
        end else begin
            q = (longint'(MAX_DUTY) * t) / longint'(period_us);
            if (q > MAX_DUTY)
                q = MAX_DUTY;
        end
        res.duty  = q[15:0];
        res.angle = target[15:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        servo_result_t want;
        servo_result_t got;
        if (!aresetn) begin
            period_us    = 16'd20000;
            ang_first    = 16'sd0;
            pulse_first  = 16'd500;
            ang_second   = 16'sd180;
            pulse_second = 16'd2500;
            held_ang     = 16'sd0;
            expected_results.delete();
            mismatches   = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CYCLE:      period_us    = cfg_data;
                    REG_FIRST_ANG:  ang_first    = cfg_data;
                    REG_FIRST_T:    pulse_first  = cfg_data;
                    REG_SECOND_ANG: ang_second   = cfg_data;
                    REG_SECOND_T:   pulse_second = cfg_data;
                    default: ;
                endcase
            end
            // results, oldest expectation first
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    log_mismatch("unexpected result, angle", 0,
                                 longint'($signed(got.angle)));
                end else begin
                    want = expected_results.pop_front();
                    if (got.duty !== want.duty)
                        log_mismatch("duty", want.duty, got.duty);
                    if (got.angle !== want.angle)
                        log_mismatch("current_angle", longint'($signed(want.angle)),
                                     longint'($signed(got.angle)));
                end
            end
            // input items
            if (s_tvalid && s_tready) begin
                want = predict_servo(s_tuser, s_tdata);
                held_ang = want.angle;
                expected_results.push_back(want);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> bench/servo_angle_to_pwm_duty_tb.sv
// Top of the servo_angle_to_pwm_duty regression: clock, reset, item and register
// stimulus with random idling, and the verdict.
// Depends on sapwm_pkg, servo_angle_to_pwm_duty and servo_angle_to_pwm_duty_chk.
module servo_angle_to_pwm_duty_tb;
    import sapwm_pkg::*;

    localparam int DUTY_FULL    = MAX_DUTY_DEF;
    localparam int ITEMS        = 1650;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int LONG_HOLD    = 1000;
    localparam int DRAIN_CYCLES = 160;
    // unused kind code; the block treats it as a rotate by zero
    localparam logic [1:0] KIND_HOLD = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] angle_value
    logic [1:0]  s_tuser;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [15:0] duty, [31:16] current_angle
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int mismatches;
    int outstanding;
    int sent;
    int cycles = 0;
    int cur_a1;
    int cur_a2;
    bit quiet;      // no idling on either side
    bit hold_req;   // ask the receiver for one long hold-off

    servo_angle_to_pwm_duty #(
        .MAX_DUTY (DUTY_FULL)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_angle_to_pwm_duty_chk #(
        .MAX_DUTY (DUTY_FULL)
    ) i_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("servo_angle_to_pwm_duty regression: fail");
            $finish;
        end
    end

    // Idle length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Offer one item and wait until it is taken; returns on a falling edge
    task automatic send_item(input logic [1:0] kind, input logic [15:0] value);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = kind;
        s_tdata  = value;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Wait for the block to drain, then load all five registers
    task automatic apply_setup(input int cyc, a1, t1, a2, t2);
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        write_reg(REG_CYCLE, cyc[15:0]);
        write_reg(REG_FIRST_ANG, a1[15:0]);
        write_reg(REG_FIRST_T, t1[15:0]);
        write_reg(REG_SECOND_ANG, a2[15:0]);
        write_reg(REG_SECOND_T, t2[15:0]);
        cfg_valid = 1'b0;
        cur_a1 = a1;
        cur_a2 = a2;
    endtask

    // Random setting: mostly servo-like, sometimes the corners
    task automatic random_setup();
        int r, cyc, a1, a2, t1, t2;
        r  = $urandom_range(0, 9);
        a1 = $urandom_range(0, 400);
        a1 = a1 - 200;
        a2 = $urandom_range(0, 400);
        a2 = a2 - 200;
        t1 = $urandom_range(400, 2600);
        t2 = $urandom_range(400, 2600);
        cyc = $urandom_range(2500, 30000);
        case (r)
            6: begin  // anything the registers can hold
                cyc = $urandom_range(0, 65535);
                a1 = $urandom_range(0, 65535);
                a1 = a1 - 32768;
                a2 = $urandom_range(0, 65535);
                a2 = a2 - 32768;
                t1 = $urandom_range(0, 65535);
                t2 = $urandom_range(0, 65535);
            end
            7: a2 = a1;  // equal endpoints
            8: begin  // short period, wide pulses: duty saturates, zero period too
                cyc = $urandom_range(0, 1500);
                t1 = $urandom_range(0, 65535);
                t2 = $urandom_range(0, 65535);
            end
            9: begin  // full travel, either way round
                a1 = -32768;
                a2 = 32767;
                if ($urandom_range(0, 1) == 1) begin
                    a1 = 32767;
                    a2 = -32768;
                end
                t1 = $urandom_range(0, 65535);
                t2 = $urandom_range(0, 65535);
            end
            default: ;
        endcase
        apply_setup(cyc, a1, t1, a2, t2);
    endtask

    // Random item, values mostly near the current travel
    task automatic send_random_item();
        int r, lo, hi, x;
        logic [1:0] k;
        lo = (cur_a1 < cur_a2) ? cur_a1 : cur_a2;
        hi = (cur_a1 < cur_a2) ? cur_a2 : cur_a1;
        r = $urandom_range(0, 99);
        if (r < 35)
            k = KIND_SET;
        else if (r < 75)
            k = KIND_ROT;
        else if (r < 90)
            k = KIND_CTR;
        else
            k = KIND_HOLD;
        if ($urandom_range(0, 9) < 3)
            x = $urandom;
        else if (k == KIND_ROT)
            x = $urandom_range(0, 2 * (hi - lo) + 8) - (hi - lo) - 4;
        else
            x = lo - 20 + $urandom_range(0, hi - lo + 40);
        send_item(k, x[15:0]);
    endtask

    // Receiver: random stalls, quiet stretches, one long hold-off on request
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                // output register fills, then the block stops taking items
                hold_done = 1'b1;
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (quiet) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int seg, n, i;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_SET;
        cfg_valid = 1'b0;
        cfg_index = REG_CYCLE;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        sent      = 0;
        cur_a1    = 0;
        cur_a2    = 180;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // reset setting: 0..180 degrees, 500..2500 us, 20 ms period
        send_item(KIND_SET, 16'd90);
        send_item(KIND_SET, 16'h7FFF);     // clamps to upper end
        send_item(KIND_SET, 16'h8000);     // clamps to lower end
        send_item(KIND_ROT, 16'd45);
        send_item(KIND_ROT, 16'h7FFF);     // wide rotate, no wrap
        send_item(KIND_ROT, 16'h8000);
        send_item(KIND_SET, 16'd137);
        send_item(KIND_HOLD, 16'hFFFF);
        send_item(KIND_CTR, 16'h5555);

        // endpoints given high first
        apply_setup(20000, 90, 1000, -90, 2000);
        send_item(KIND_CTR, 16'd0);
        send_item(KIND_SET, 16'hFFE2);
        // pulse time falls as the angle rises
        apply_setup(20000, 0, 2500, 180, 500);
        send_item(KIND_SET, 16'd77);
        send_item(KIND_ROT, 16'd33);
        // equal endpoints
        apply_setup(20000, 45, 700, 45, 1900);
        send_item(KIND_SET, 16'd0);
        send_item(KIND_CTR, 16'd0);
        // recenter with travel all above zero, then all below
        apply_setup(20000, 10, 600, 100, 2400);
        send_item(KIND_CTR, 16'd0);
        apply_setup(20000, -100, 600, -10, 2400);
        send_item(KIND_CTR, 16'd0);
        // full travel, full pulse range, longest period
        apply_setup(65535, -32768, 0, 32767, 65535);
        send_item(KIND_SET, 16'h7FFF);
        send_item(KIND_ROT, 16'h7FFF);
        send_item(KIND_SET, 16'h8000);
        send_item(KIND_ROT, 16'h8000);
        // zero period
        apply_setup(0, 0, 500, 180, 2500);
        send_item(KIND_SET, 16'd5);
        // one us period: duty saturates
        apply_setup(1, -32768, 65535, 32767, 65535);
        send_item(KIND_SET, 16'd1234);

        // random segments, each under its own setting
        seg = 0;
        while (sent < ITEMS) begin
            random_setup();
            quiet = ($urandom_range(0, 4) == 0);
            if (seg == 2) begin
                quiet    = 1'b0;
                hold_req = 1'b1;
            end
            n = $urandom_range(20, 60);
            for (i = 0; i < n && sent < ITEMS; i++)
                send_random_item();
            seg++;
        end
        s_tvalid = 1'b0;
        quiet = 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("servo_angle_to_pwm_duty regression: pass");
        else
            $display("servo_angle_to_pwm_duty regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/sapwm_pkg.sv
sv/sapwm_div.sv
sv/servo_angle_to_pwm_duty.sv
bench/servo_angle_to_pwm_duty_chk.sv
bench/servo_angle_to_pwm_duty_tb.sv
